// File: src/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

  localparam int OP_W       = 2;
  localparam int SIZE_W     = 16;
  localparam int INDEX_W    = 10;
  localparam int STATUS_W   = 3;
  localparam int USED_W     = 11;
  localparam int FRAG_W     = 17;
  localparam int FRAC_BITS  = 16;

  localparam int DEF_NUM_BLOCKS = 1024;

  localparam logic [SIZE_W-1:0] PAYLOAD_LIMIT_RESET = 16'd56;
  localparam logic [FRAG_W-1:0] FRAG_ONE            = 17'h10000;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd4;

  typedef struct packed {
    logic              done;
    logic [FRAG_W-1:0] ratio;
  } div_res_t;

endpackage

`default_nettype wire

// File: src/fbpa_req_if.sv
`default_nettype none

interface fbpa_req_if;
  import fbpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SIZE_W-1:0]   request_size;
  logic [INDEX_W-1:0]  block_index;

  modport source (output valid, output op, output request_size, output block_index,
                  input ready);
  modport sink   (input valid, input op, input request_size, input block_index,
                  output ready);
endinterface

`default_nettype wire

// File: src/fbpa_rsp_if.sv
`default_nettype none

interface fbpa_rsp_if;
  import fbpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  granted_index;
  logic [USED_W-1:0]   used_count;
  logic [FRAG_W-1:0]   frag_ratio;

  modport source (output valid, output status, output granted_index, output used_count,
                  output frag_ratio, input ready);
  modport sink   (input valid, input status, input granted_index, input used_count,
                  input frag_ratio, output ready);
endinterface

`default_nettype wire

// File: src/fbpa_div.sv
`default_nettype none

module fbpa_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  numer,
  input  wire logic [DEN_W-1:0]  denom,
  output fbpa_pkg::div_res_t     res
);
  import fbpa_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] numq;
  logic [NUM_W-1:0] quot;

  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, numq[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      den  <= denom;
      numq <= numer;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      numq <= {numq[NUM_W-2:0], 1'b0};
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

  assign res.done  = done;
  assign res.ratio = (quot > NUM_W'(FRAG_ONE)) ? FRAG_ONE : FRAG_W'(quot);

endmodule

`default_nettype wire

// File: src/fixed_block_pool_allocator_top.sv
`default_nettype none

// channel   dir  words                                     handshake
// req       in   op, request_size, block_index             valid/ready
// rsp       out  status, granted_index, used_count, frag   valid/ready
// cfg       in   payload_limit                             cfg_we, no wait
//
// Allocate and free do three reads and one write on the single-port block table
// (link and allocation bit per block); freeing a free block skips the write. Query
// uses the one-bit-a-cycle divider when more than one and fewer than all blocks
// are in use. Rejected requests, trivial queries and the unused code go straight
// to the result. Reset is synchronous; no clearing pass, entries at or above the
// high-water mark read as free. A stalled result holds in the output register.

module fixed_block_pool_allocator_top #(
  parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [fbpa_pkg::SIZE_W-1:0] cfg_wdata,
  fbpa_req_if.sink                        req,
  fbpa_rsp_if.source                      rsp
);
  import fbpa_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = IDX_W + 1;
  localparam int WRD_W = IDX_W + 1;
  localparam int NUM_W = CNT_W + FRAC_BITS;
  localparam int DEN_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_RD3  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]          state;
  logic [SIZE_W-1:0]   payload_limit;
  logic [IDX_W-1:0]    head;
  logic [CNT_W-1:0]    hwm;
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    edges;

  logic [OP_W-1:0]     op_q;
  logic [IDX_W-1:0]    blk;
  logic [STATUS_W-1:0] status_q;
  logic [INDEX_W-1:0]  granted_q;
  logic [FRAG_W-1:0]   frag_q;
  logic [IDX_W-1:0]    self_link;
  logic                self_valid;
  logic                self_bit;
  logic                left_bit;
  logic                right_bit;

  logic [WRD_W-1:0]    table_mem [NUM_BLOCKS];
  logic [WRD_W-1:0]    mem_q;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    rd_addr_q;
  logic                mem_we;
  logic [WRD_W-1:0]    mem_wdata;
  logic                rd_hit;
  logic                rd_bit;

  logic                has_left;
  logic                has_right;
  logic                old_bit;
  logic [CNT_W-1:0]    e_inc;
  logic [CNT_W-1:0]    e_dec;
  logic [CNT_W-1:0]    edges_next;

  logic                div_start;
  div_res_t            div_res;
  logic                accept;
  logic                rsp_free;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp_free = !rsp.valid || rsp.ready;

  always_comb begin
    unique case (state)
      S_RD1:   rd_addr = blk - IDX_W'(1);
      S_RD2:   rd_addr = blk + IDX_W'(1);
      default: rd_addr = blk;
    endcase
  end

  assign rd_hit = ({1'b0, rd_addr_q} < hwm);
  assign rd_bit = rd_hit && mem_q[WRD_W-1];

  assign has_left  = (blk != '0);
  assign has_right = (blk != IDX_W'(NUM_BLOCKS - 1));
  assign old_bit   = self_bit;

  assign e_inc = CNT_W'(has_left && (left_bit == old_bit))
               + CNT_W'(has_right && (right_bit == old_bit));
  assign e_dec = CNT_W'(has_left && (left_bit != old_bit))
               + CNT_W'(has_right && (right_bit != old_bit));
  assign edges_next = edges + e_inc - e_dec;

  assign mem_we    = (state == S_UPD) && ((op_q == OP_ALLOC) || self_bit);
  assign mem_wdata = (op_q == OP_ALLOC) ? {1'b1, self_link} : {1'b0, head};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[blk] <= mem_wdata;
    end
    mem_q     <= table_mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  assign div_start = accept && (req.op == OP_QUERY)
                     && (used > CNT_W'(1)) && (used < CNT_W'(NUM_BLOCKS));

  fbpa_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer ({edges, FRAC_BITS'(0)}),
    .denom ({used, 1'b0}),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      payload_limit <= PAYLOAD_LIMIT_RESET;
      head          <= '0;
      hwm           <= '0;
      used          <= '0;
      edges         <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        payload_limit <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= req.op;
            status_q  <= ST_OK;
            granted_q <= '0;
            frag_q    <= '0;
            state     <= S_OUT;
            case (req.op)
              OP_ALLOC: begin
                if (req.request_size > payload_limit) begin
                  status_q <= ST_TOO_LARGE;
                end else if (used == CNT_W'(NUM_BLOCKS)) begin
                  status_q <= ST_EMPTY;
                end else begin
                  blk   <= head;
                  state <= S_RD0;
                end
              end
              OP_FREE: begin
                if (32'(req.block_index) >= 32'(NUM_BLOCKS)) begin
                  status_q <= ST_RANGE;
                end else begin
                  blk   <= IDX_W'(req.block_index);
                  state <= S_RD0;
                end
              end
              OP_QUERY: begin
                if (div_start) begin
                  state <= S_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          self_link  <= mem_q[IDX_W-1:0];
          self_valid <= rd_hit;
          self_bit   <= rd_bit;
          state      <= S_RD2;
        end
        S_RD2: begin
          left_bit <= rd_bit;
          state    <= S_RD3;
        end
        S_RD3: begin
          right_bit <= rd_bit;
          state     <= S_UPD;
        end
        S_UPD: begin
          state <= S_OUT;
          if (op_q == OP_ALLOC) begin
            edges     <= edges_next;
            used      <= used + CNT_W'(1);
            granted_q <= INDEX_W'(blk);
            if (self_valid) begin
              head <= self_link;
            end else begin
              head <= blk + IDX_W'(1);
              hwm  <= hwm + CNT_W'(1);
            end
          end else if (!self_bit) begin
            status_q <= ST_NOT_ALLOC;
          end else begin
            edges <= edges_next;
            used  <= used - CNT_W'(1);
            head  <= blk;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            frag_q <= div_res.ratio;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (rsp_free) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && rsp_free) begin
      rsp.status        <= status_q;
      rsp.granted_index <= granted_q;
      rsp.used_count    <= USED_W'(used);
      rsp.frag_ratio    <= frag_q;
    end
  end

endmodule

`default_nettype wire
